@@ hdl/pecq_pkg.sv @@
// shared types and constants for the pulse edge capture queue
`default_nettype none
package pecq_pkg;

    localparam int TS_W = 16;
    localparam int ENTRY_W = 3 * TS_W;
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    typedef enum logic {
        KIND_CAPTURE = 1'b0,
        KIND_DEQUEUE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        OP_NOTE = 2'd0,
        OP_ENQ  = 2'd1,
        OP_DEQ  = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [TS_W-1:0]  t_start;
        logic [TS_W-1:0]  t_mid;
        logic [TS_W-1:0]  t_stop;
    } cmd_t;

    typedef struct packed {
        logic             sample_valid;
        logic [TS_W-1:0]  period_start;
        logic [TS_W-1:0]  pulse_mid;
        logic [TS_W-1:0]  period_stop;
        logic             dropped;
    } result_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } back_state_t;

endpackage
`default_nettype wire

@@ hdl/pecq_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module pecq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ hdl/pecq_front.sv @@
// front end: accepts items, tracks edge polarity and builds commands
`default_nettype none
module pecq_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire logic                        kind,
    input  wire logic [pecq_pkg::TS_W-1:0]   timestamp,
    output logic                             full,
    input  wire logic                        cmd_full,
    output logic                             cmd_push,
    output pecq_pkg::cmd_t                   cmd
);

    logic                      expect_rising_reg;
    logic                      expect_rising_next;
    logic [pecq_pkg::TS_W-1:0] start_reg;
    logic [pecq_pkg::TS_W-1:0] start_next;
    logic [pecq_pkg::TS_W-1:0] mid_reg;
    logic [pecq_pkg::TS_W-1:0] mid_next;
    logic                      accept;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    always_comb
    begin
        expect_rising_next = expect_rising_reg;
        start_next         = start_reg;
        mid_next           = mid_reg;
        cmd_push           = accept;
        cmd.op             = pecq_pkg::OP_NOTE;
        cmd.t_start        = start_reg;
        cmd.t_mid          = mid_reg;
        cmd.t_stop         = timestamp;
        if (accept)
        begin
            if (pecq_pkg::kind_t'(kind) == pecq_pkg::KIND_DEQUEUE)
            begin
                cmd.op = pecq_pkg::OP_DEQ;
            end
            else if (expect_rising_reg)
            begin
                cmd.op             = pecq_pkg::OP_ENQ;
                start_next         = timestamp;
                expect_rising_next = 1'b0;
            end
            else
            begin
                mid_next           = timestamp;
                expect_rising_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_rising_reg <= 1'b1;
            start_reg         <= '0;
            mid_reg           <= '0;
        end
        else
        begin
            expect_rising_reg <= expect_rising_next;
            start_reg         <= start_next;
            mid_reg           <= mid_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/pecq_cmd_fifo.sv @@
// short command queue between front and back
`default_nettype none
module pecq_cmd_fifo (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire pecq_pkg::cmd_t wr_data,
    output logic         full,
    input  wire logic    rd_en,
    output pecq_pkg::cmd_t rd_data,
    output logic         empty
);

    pecq_pkg::cmd_t                  slot_reg [pecq_pkg::CMD_DEPTH];
    logic [pecq_pkg::CMD_PTR_W-1:0]  wr_ptr_reg;
    logic [pecq_pkg::CMD_PTR_W-1:0]  wr_ptr_next;
    logic [pecq_pkg::CMD_PTR_W-1:0]  rd_ptr_reg;
    logic [pecq_pkg::CMD_PTR_W-1:0]  rd_ptr_next;
    logic [pecq_pkg::CMD_CNT_W-1:0]  count_reg;
    logic [pecq_pkg::CMD_CNT_W-1:0]  count_next;
    logic                            do_wr;
    logic                            do_rd;

    assign full    = (count_reg == pecq_pkg::CMD_CNT_W'(pecq_pkg::CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == pecq_pkg::CMD_PTR_W'(pecq_pkg::CMD_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == pecq_pkg::CMD_PTR_W'(pecq_pkg::CMD_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/pecq_back.sv @@
// back end: ring queue of triples, dequeue sequencing and result register
`default_nettype none
module pecq_back #(
    parameter int QUEUE_SLOTS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_empty,
    input  wire pecq_pkg::cmd_t cmd,
    output logic             cmd_pop,
    input  wire logic        pop,
    output logic             empty,
    output pecq_pkg::result_t result
);

    localparam int PTR_W = $clog2(QUEUE_SLOTS);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);

    pecq_pkg::back_state_t             state_reg;
    pecq_pkg::back_state_t             state_next;
    logic [PTR_W-1:0]                  wp_reg;
    logic [PTR_W-1:0]                  wp_next;
    logic [PTR_W-1:0]                  rp_reg;
    logic [PTR_W-1:0]                  rp_next;
    logic [PTR_W-1:0]                  wp_inc;
    logic [PTR_W-1:0]                  rp_inc;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    pecq_pkg::result_t                 res_reg;
    pecq_pkg::result_t                 res_next;
    logic                              load;
    logic                              out_free;
    logic                              ram_wr_en;
    logic                              ram_rd_en;
    logic [pecq_pkg::ENTRY_W-1:0]      ram_wr_data;
    logic [pecq_pkg::ENTRY_W-1:0]      ram_rd_data;

    assign wp_inc      = (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;
    assign rp_inc      = (rp_reg == LAST_SLOT) ? '0 : rp_reg + 1'b1;
    assign out_free    = !out_valid_reg || pop;
    assign ram_wr_data = {cmd.t_start, cmd.t_mid, cmd.t_stop};

    pecq_ram #(
        .WIDTH (pecq_pkg::ENTRY_W),
        .DEPTH (QUEUE_SLOTS)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rp_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        cmd_pop    = 1'b0;
        ram_wr_en  = 1'b0;
        ram_rd_en  = 1'b0;
        load       = 1'b0;
        res_next   = '0;
        case (state_reg)
            pecq_pkg::ST_IDLE:
            begin
                if (!cmd_empty && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        pecq_pkg::OP_ENQ:
                        begin
                            load = 1'b1;
                            if (wp_inc == rp_reg)
                            begin
                                res_next.dropped = 1'b1;
                            end
                            else
                            begin
                                ram_wr_en = 1'b1;
                                wp_next   = wp_inc;
                            end
                        end
                        pecq_pkg::OP_DEQ:
                        begin
                            if (rp_reg == wp_reg)
                            begin
                                load = 1'b1;
                            end
                            else
                            begin
                                ram_rd_en  = 1'b1;
                                rp_next    = rp_inc;
                                state_next = pecq_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            pecq_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    load                  = 1'b1;
                    res_next.sample_valid = 1'b1;
                    res_next.period_start = ram_rd_data[3*pecq_pkg::TS_W-1:2*pecq_pkg::TS_W];
                    res_next.pulse_mid    = ram_rd_data[2*pecq_pkg::TS_W-1:pecq_pkg::TS_W];
                    res_next.period_stop  = ram_rd_data[pecq_pkg::TS_W-1:0];
                    state_next            = pecq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pecq_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = load ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pecq_pkg::ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = res_reg;

    a_valid_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.sample_valid && res_reg.dropped))
        else $error("result both valid and dropped");

    a_read_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pecq_pkg::ST_IDLE && ram_rd_en) |=> state_reg == pecq_pkg::ST_READ)
        else $error("ring read issued without waiting for data");

    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= LAST_SLOT)
        else $error("write pointer out of range");

    a_rp_range: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg <= LAST_SLOT)
        else $error("read pointer out of range");

endmodule
`default_nettype wire

@@ hdl/pulse_edge_capture_queue.sv @@
// top level: input capture period and pulse width queue
// path: a capture item passes through the command queue to the result register; a dequeue
// that finds a stored triple also waits in the read state for the ring ram read
// throughput: one item per cycle while results are drained; each dequeue that
// returns a triple also holds the back end in its read state (registered ram read)
// reset: edge polarity to rising, start and mid times and all pointers cleared,
// ring ram contents left as they are
`default_nettype none
module pulse_edge_capture_queue #(
    parameter int QUEUE_SLOTS = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic                      kind,
    input  wire logic [pecq_pkg::TS_W-1:0] timestamp,
    output logic                           empty,
    input  wire logic                      pop,
    output logic                           sample_valid,
    output logic [pecq_pkg::TS_W-1:0]      period_start,
    output logic [pecq_pkg::TS_W-1:0]      pulse_mid,
    output logic [pecq_pkg::TS_W-1:0]      period_stop,
    output logic                           dropped
);

    pecq_pkg::cmd_t    front_cmd;
    pecq_pkg::cmd_t    back_cmd;
    pecq_pkg::result_t result;
    logic              cmd_push;
    logic              cmd_full;
    logic              cmd_pop;
    logic              cmd_empty;

    pecq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .kind      (kind),
        .timestamp (timestamp),
        .full      (full),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd)
    );

    pecq_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    pecq_back #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    assign sample_valid = result.sample_valid;
    assign period_start = result.period_start;
    assign pulse_mid    = result.pulse_mid;
    assign period_stop  = result.period_stop;
    assign dropped      = result.dropped;

endmodule
`default_nettype wire

@@ tb/pulse_edge_capture_queue_chk.sv @@
// checker: predicts capture queue results from accepted items and compares them
`timescale 1ns / 1ps
module pulse_edge_capture_queue_chk #(
    parameter int QUEUE_SLOTS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic                      full,
    input  logic                      kind,
    input  logic [pecq_pkg::TS_W-1:0] timestamp,
    input  logic                      empty,
    input  logic                      pop,
    input  logic                      sample_valid,
    input  logic [pecq_pkg::TS_W-1:0] period_start,
    input  logic [pecq_pkg::TS_W-1:0] pulse_mid,
    input  logic [pecq_pkg::TS_W-1:0] period_stop,
    input  logic                      dropped,
    output int                        fail_count,
    output int                        pending,
    output int                        results_checked,
    output int                        triples_seen,
    output int                        drops_seen,
    output int                        empty_deqs
);

    logic                           await_rise;
    logic [pecq_pkg::TS_W-1:0]      open_start;
    logic [pecq_pkg::TS_W-1:0]      open_mid;
    logic [pecq_pkg::ENTRY_W-1:0]   period_ring [QUEUE_SLOTS];
    int                             ring_wr;
    int                             ring_rd;
    pecq_pkg::result_t              expected_results [$];

    task automatic predict_item(input logic k, input logic [pecq_pkg::TS_W-1:0] ts);
        pecq_pkg::result_t r;
        int                nxt;
        r = '0;
        if (k == pecq_pkg::KIND_CAPTURE)
        begin
            if (await_rise)
            begin
                nxt = (ring_wr + 1) % QUEUE_SLOTS;
                if (nxt != ring_rd)
                begin
                    period_ring[ring_wr] = {open_start, open_mid, ts};
                    ring_wr = nxt;
                end
                else
                begin
                    r.dropped = 1'b1;
                end
                open_start = ts;
            end
            else
            begin
                open_mid = ts;
            end
            await_rise = !await_rise;
        end
        else if (ring_rd != ring_wr)
        begin
            r.sample_valid = 1'b1;
            {r.period_start, r.pulse_mid, r.period_stop} = period_ring[ring_rd];
            ring_rd = (ring_rd + 1) % QUEUE_SLOTS;
        end
        else
        begin
            empty_deqs++;
        end
        expected_results.push_back(r);
    endtask

    task automatic compare_field(input string name, input logic [pecq_pkg::TS_W-1:0] want,
                                 input logic [pecq_pkg::TS_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        pecq_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual valid %b %h %h %h drop %b",
                     $time, sample_valid, period_start, pulse_mid, period_stop, dropped);
            fail_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            compare_field("sample_valid", pecq_pkg::TS_W'(want.sample_valid),
                          pecq_pkg::TS_W'(sample_valid));
            compare_field("period_start", want.period_start, period_start);
            compare_field("pulse_mid", want.pulse_mid, pulse_mid);
            compare_field("period_stop", want.period_stop, period_stop);
            compare_field("dropped", pecq_pkg::TS_W'(want.dropped), pecq_pkg::TS_W'(dropped));
            results_checked++;
            if (want.sample_valid)
                triples_seen++;
            if (want.dropped)
                drops_seen++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            await_rise = 1'b1;
            open_start = '0;
            open_mid = '0;
            ring_wr = 0;
            ring_rd = 0;
            expected_results.delete();
            fail_count = 0;
            results_checked = 0;
            triples_seen = 0;
            drops_seen = 0;
            empty_deqs = 0;
        end
        else
        begin
            if (push && !full)
                predict_item(kind, timestamp);
            if (pop && !empty)
                check_result();
        end
        pending = expected_results.size();
    end

endmodule

@@ tb/pulse_edge_capture_queue_tb.sv @@
// testbench top: drives capture and dequeue items and reports the verdict
`timescale 1ns / 1ps
module pulse_edge_capture_queue_tb;

    localparam int QUEUE_SLOTS = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 10;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic                      kind;
    logic [pecq_pkg::TS_W-1:0] timestamp;
    logic                      empty;
    logic                      pop;
    logic                      sample_valid;
    logic [pecq_pkg::TS_W-1:0] period_start;
    logic [pecq_pkg::TS_W-1:0] pulse_mid;
    logic [pecq_pkg::TS_W-1:0] period_stop;
    logic                      dropped;

    int fail_count;
    int pending;
    int results_checked;
    int triples_seen;
    int drops_seen;
    int empty_deqs;
    int items_sent;
    int idle_cycles;
    int phase;
    int n;
    int deq_pct;
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;

    pulse_edge_capture_queue #(
        .QUEUE_SLOTS(QUEUE_SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .kind(kind),
        .timestamp(timestamp),
        .empty(empty),
        .pop(pop),
        .sample_valid(sample_valid),
        .period_start(period_start),
        .pulse_mid(pulse_mid),
        .period_stop(period_stop),
        .dropped(dropped)
    );

    pulse_edge_capture_queue_chk #(
        .QUEUE_SLOTS(QUEUE_SLOTS)
    ) i_chk (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .kind(kind),
        .timestamp(timestamp),
        .empty(empty),
        .pop(pop),
        .sample_valid(sample_valid),
        .period_start(period_start),
        .pulse_mid(pulse_mid),
        .period_stop(period_stop),
        .dropped(dropped),
        .fail_count(fail_count),
        .pending(pending),
        .results_checked(results_checked),
        .triples_seen(triples_seen),
        .drops_seen(drops_seen),
        .empty_deqs(empty_deqs)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [pecq_pkg::TS_W-1:0] pick_stamp();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return pecq_pkg::TS_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_item(input pecq_pkg::kind_t k, input logic [pecq_pkg::TS_W-1:0] ts);
        if (idle_on && $urandom_range(0, 99) < 21)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push <= 1'b1;
        kind <= k;
        timestamp <= ts;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                pop <= !idle_on || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("pulse_edge_capture_queue regression: fail");
        $finish;
    end

    initial
    begin
        items_sent = 0;
        rst_n <= 1'b0;
        push <= 1'b0;
        kind <= pecq_pkg::KIND_CAPTURE;
        timestamp <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // dequeue on empty, first rising edge, extreme stamps
        send_item(pecq_pkg::KIND_DEQUEUE, 16'hffff);
        send_item(pecq_pkg::KIND_CAPTURE, 16'h1234);
        send_item(pecq_pkg::KIND_CAPTURE, 16'hffff);
        send_item(pecq_pkg::KIND_CAPTURE, 16'h0000);
        send_item(pecq_pkg::KIND_CAPTURE, 16'h0000);
        send_item(pecq_pkg::KIND_CAPTURE, 16'hffff);
        send_item(pecq_pkg::KIND_CAPTURE, 16'haaaa);
        send_item(pecq_pkg::KIND_CAPTURE, 16'h5555);
        send_item(pecq_pkg::KIND_DEQUEUE, 16'h0000);
        send_item(pecq_pkg::KIND_DEQUEUE, 16'hffff);
        send_item(pecq_pkg::KIND_DEQUEUE, 16'h5a5a);
        send_item(pecq_pkg::KIND_DEQUEUE, 16'ha5a5);
        send_item(pecq_pkg::KIND_DEQUEUE, 16'h0000);
        send_item(pecq_pkg::KIND_CAPTURE, 16'h8000);
        send_item(pecq_pkg::KIND_DEQUEUE, 16'h0001);
        wait_drained();

        // receiver holds off pops to stall the queue, then the captures overflow the ring
        hold_req = 1'b1;
        repeat (100) send_item(pecq_pkg::KIND_CAPTURE, pick_stamp());
        wait_drained();
        repeat (40) send_item(pecq_pkg::KIND_DEQUEUE, pick_stamp());
        wait_drained();

        for (phase = 0; phase < 10; phase++)
        begin
            idle_on = (phase != 4);
            deq_pct = $urandom_range(1, 9) * 10;
            for (n = 0; n < 95; n++)
                send_item(pecq_pkg::kind_t'($urandom_range(0, 99) < deq_pct), pick_stamp());
            if (phase % 2 == 1)
                wait_drained();
        end
        idle_on = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items and %0d results: %0d triples returned,", items_sent,
                 results_checked, triples_seen);
        $display("%0d periods dropped on a full ring, %0d dequeues of an empty ring",
                 drops_seen, empty_deqs);
        if (fail_count == 0)
            $display("pulse_edge_capture_queue regression: pass");
        else
            $display("pulse_edge_capture_queue regression: fail");
        $finish;
    end

endmodule
